[hdl/xtea_pkg.sv]
// shared types, constants and helper functions for the xtea cipher unit
// no dependencies; imported by xtea_stage and xtea_block_cipher_unit
package xtea_pkg;

    localparam int WORD_W    = 32;
    localparam int KEY_WORDS = 4;
    localparam int KEY_IDX_W = $clog2(KEY_WORDS);
    localparam int APB_ADDR_W = KEY_IDX_W + 2;

    // default number of full cipher rounds
    localparam int XTEA_ROUNDS = 32;

    localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E3779B9;

    // action codes
    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    localparam logic [KEY_WORDS-1:0][WORD_W-1:0] KEY_RESET = {
        32'h16DB7FC2,
        32'h3A170B92,
        32'h03827D0F,
        32'h6C0A5452
    };

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] xtea_key_t;

    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] first_word;
        logic [WORD_W-1:0] second_word;
    } xtea_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] out_first_word;
        logic [WORD_W-1:0] out_second_word;
    } xtea_out_t;

    // block as it moves down the round pipeline
    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
    } xtea_blk_t;

    function automatic logic [WORD_W-1:0] xtea_mix(input logic [WORD_W-1:0] w);
        return ((w << 4) ^ (w >> 5)) + w;
    endfunction

    // running sum after n delta steps, mod 2^32
    function automatic logic [WORD_W-1:0] xtea_sum(input int n);
        logic [2*WORD_W-1:0] prod;
        prod = 64'(XTEA_DELTA) * 64'(n);
        return prod[WORD_W-1:0];
    endfunction

endpackage

[hdl/xtea_stage.sv]
// one half-round of the xtea cycle followed by its pipeline register
// depends on xtea_pkg (block type, mix and sum helpers)
module xtea_stage import xtea_pkg::*; #(
    parameter int ROUNDS = XTEA_ROUNDS,
    parameter int STEP   = 0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      adv,
    input  logic      in_valid,
    input  xtea_blk_t in_blk,
    input  xtea_key_t key,
    output logic      out_valid,
    output xtea_blk_t out_blk
);

    localparam logic ODD = ((STEP % 2) == 1) ? 1'b1 : 1'b0;

    // sum values seen by this half-round in each direction
    localparam logic [WORD_W-1:0] ENC_SUM = xtea_sum((STEP + 1) / 2);
    localparam logic [WORD_W-1:0] DEC_SUM = xtea_sum(ROUNDS - (STEP + 1) / 2);

    localparam logic [KEY_IDX_W-1:0] ENC_KI = ODD ? ENC_SUM[12:11] : ENC_SUM[1:0];
    localparam logic [KEY_IDX_W-1:0] DEC_KI = ODD ? DEC_SUM[1:0]   : DEC_SUM[12:11];

    logic              tgt_y;
    logic [WORD_W-1:0] src_w;
    logic [WORD_W-1:0] tgt_w;
    logic [WORD_W-1:0] keyed;
    logic [WORD_W-1:0] f_w;
    logic [WORD_W-1:0] res_w;
    xtea_blk_t         blk_next;
    xtea_blk_t         blk_reg;
    logic              valid_reg;

    always_comb begin
        // encrypt updates y on even steps, decrypt updates y on odd steps
        tgt_y = (in_blk.action == ODD);
        src_w = tgt_y ? in_blk.z : in_blk.y;
        tgt_w = tgt_y ? in_blk.y : in_blk.z;
        keyed = (in_blk.action == ACT_DECRYPT) ? (DEC_SUM + key[DEC_KI])
                                               : (ENC_SUM + key[ENC_KI]);
        f_w   = xtea_mix(src_w) ^ keyed;
        res_w = (in_blk.action == ACT_DECRYPT) ? (tgt_w - f_w) : (tgt_w + f_w);

        blk_next.action = in_blk.action;
        blk_next.y      = tgt_y ? res_w : in_blk.y;
        blk_next.z      = tgt_y ? in_blk.z : res_w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            blk_reg <= blk_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_blk   = blk_reg;

endmodule

[hdl/xtea_block_cipher_unit.sv]
// xtea cipher unit: 2*ROUNDS half-round stages, output register and skid beat
// each input beat passes through the half-round stage registers and then the output register
// throughput one beat per cycle; the pipeline advances unless the skid beat is full
// synchronous active-low reset clears all valid bits and loads the default key
// depends on xtea_pkg and xtea_stage
module xtea_block_cipher_unit import xtea_pkg::*; #(
    parameter int ROUNDS = XTEA_ROUNDS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  xtea_in_t              s_data,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output xtea_out_t             m_data,
    // key register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0]     pwdata,
    output logic [WORD_W-1:0]     prdata,
    output logic                  pready
);

    // two half-rounds per round, one register stage each
    localparam int NSTAGE = 2 * ROUNDS;

    // ------------------------------------------------------------------
    // key registers
    // ------------------------------------------------------------------
    xtea_key_t key_reg;
    logic      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    // word address selects the key word
    assign prdata = key_reg[paddr[APB_ADDR_W-1:2]];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= KEY_RESET;
        end else if (cfg_wr) begin
            key_reg[paddr[APB_ADDR_W-1:2]] <= pwdata;
        end
    end

    // ------------------------------------------------------------------
    // round pipeline
    // ------------------------------------------------------------------
    logic              adv;          // whole pipeline moves one stage
    logic [NSTAGE:0]   pipe_valid;
    xtea_blk_t         pipe_blk [NSTAGE+1];
    logic              skid_valid_reg;
    logic              skid_valid_next;

    // the pipeline only halts once the skid beat holds a result
    assign adv     = !skid_valid_reg;
    assign s_ready = adv;

    // stage 0 input is the accepted beat
    assign pipe_valid[0]         = s_valid && s_ready;
    assign pipe_blk[0].action    = s_data.action;
    assign pipe_blk[0].y         = s_data.first_word;
    assign pipe_blk[0].z         = s_data.second_word;

    for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
        xtea_stage #(
            .ROUNDS (ROUNDS),
            .STEP   (g)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (pipe_valid[g]),
            .in_blk    (pipe_blk[g]),
            .key       (key_reg),
            .out_valid (pipe_valid[g+1]),
            .out_blk   (pipe_blk[g+1])
        );
    end

    // ------------------------------------------------------------------
    // output register plus one skid beat
    // ------------------------------------------------------------------
    logic      tail_valid;
    xtea_out_t tail_data;
    logic      out_valid_reg;
    logic      out_valid_next;
    xtea_out_t out_data_reg;
    xtea_out_t out_data_next;
    xtea_out_t skid_data_reg;
    xtea_out_t skid_data_next;

    assign tail_valid                = pipe_valid[NSTAGE];
    assign tail_data.out_first_word  = pipe_blk[NSTAGE].y;
    assign tail_data.out_second_word = pipe_blk[NSTAGE].z;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        // output beat taken
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        if (skid_valid_reg) begin
            // drain the skid beat first; pipeline is halted meanwhile
            if (!out_valid_reg || m_ready) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (tail_valid) begin
            // pipeline is moving, so the tail beat must land somewhere
            if (!out_valid_reg || m_ready) begin
                out_valid_next = 1'b1;
                out_data_next  = tail_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = tail_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // skid beat is only ever occupied behind a held output beat
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid beat valid without output beat");

    // skid only fills when the output beat was stalled
    a_skid_fill_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready && tail_valid))
        else $error("skid filled without a stalled output");

    // a tail beat leaving into a stalled output must be caught by the skid
    a_tail_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && tail_valid && out_valid_reg && !m_ready) |=> skid_valid_reg)
        else $error("tail beat dropped");

    // no input beat is taken while the pipeline is halted
    a_no_accept_halted: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !pipe_valid[0])
        else $error("beat accepted while pipeline halted");

endmodule
